FILE: sv/rrts_pkg.sv
// ============================================================================
// Round-robin thread scheduler package
// Shared codes, widths and the command and status bundles that pass between
// the controller and the datapath.
// ============================================================================
package rrts_pkg;

    localparam int MAX_THREADS_DEF = 16;

    localparam int OP_W   = 3;
    localparam int SLOT_W = 4;
    localparam int STAT_W = 2;
    localparam int ST_W   = 2;
    localparam int CNT_W  = 32;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ATTACH    = 3'd0;
    localparam logic [OP_W-1:0] OP_CREATE    = 3'd1;
    localparam logic [OP_W-1:0] OP_TERMINATE = 3'd2;
    localparam logic [OP_W-1:0] OP_YIELD     = 3'd3;
    localparam logic [OP_W-1:0] OP_START     = 3'd4;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOTHRD  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BADSLOT = 2'd3;

    // Slot states.
    localparam logic [ST_W-1:0] ST_UNUSED     = 2'd0;
    localparam logic [ST_W-1:0] ST_READY      = 2'd1;
    localparam logic [ST_W-1:0] ST_RUNNING    = 2'd2;
    localparam logic [ST_W-1:0] ST_TERMINATED = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;       // execute a request that needs no scan straight from the inputs
        logic scan_init;  // set up the yield scan
        logic scan_step;  // issue the next table read of the scan
        logic hit;        // scan found a ready slot: mark it running
        logic miss;       // scan found nothing: report the current slot
        logic fix;        // finish the switch: demote the old slot, count
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;  // the request at the inputs is a yield that scans
        logic more;       // slots remain to be read
        logic pend;       // a read result is due this cycle
        logic hit;        // the due read result is a ready slot
    } t_sts;

endpackage

FILE: sv/rrts_ctrl.sv
// ============================================================================
// Round-robin thread scheduler controller
// Sequences one request at a time: requests that need no scan, or the yield scan
// followed by the two-step switch.
// ============================================================================
module rrts_ctrl
    import rrts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIX  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_sts.need_scan) begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end else begin
                        o_cmd.exec = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    o_cmd.hit = 1'b1;
                    n_state   = S_FIX;
                end else if (!i_sts.more && !i_sts.pend) begin
                    o_cmd.miss = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

FILE: sv/rrts_dp.sv
// ============================================================================
// Round-robin thread scheduler datapath
// Holds the slot table memory, the scheduler registers, the scan pointer and
// the result registers.
// ============================================================================
module rrts_dp
    import rrts_pkg::*;
#(
    parameter int MAX_THREADS = MAX_THREADS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [OP_W-1:0]   i_op,
    input  logic [SLOT_W-1:0] i_target_slot,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic              o_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [SLOT_W-1:0] o_slot,
    output logic              o_switched,
    output logic [CNT_W-1:0]  o_switch_count
);

    localparam int IW = $clog2(MAX_THREADS);
    localparam int CW = $clog2(MAX_THREADS + 1);
    localparam int TW = (CW > SLOT_W) ? CW : SLOT_W;

    localparam logic [CW-1:0] USED_MAX = CW'(MAX_THREADS);

    // Slot table. Entries at or above the fill count are never read, so the
    // table needs no clearing on reset or attach.
    logic [ST_W-1:0] r_mem [MAX_THREADS];
    logic [ST_W-1:0] r_rd;
    logic            mem_we;
    logic [IW-1:0]   mem_wa;
    logic [ST_W-1:0] mem_wd;

    logic [CW-1:0]   r_used,     n_used;
    logic [IW-1:0]   r_running,  n_running;
    logic            r_has_run,  n_has_run;
    logic            r_cur_run,  n_cur_run;   // running slot still in running state
    logic [CNT_W-1:0] r_switches, n_switches;

    logic [IW-1:0]   r_scan_idx, n_scan_idx;
    logic [CW-1:0]   r_left,     n_left;
    logic            r_pend,     n_pend;
    logic [IW-1:0]   r_pend_idx, n_pend_idx;

    logic              r_valid,    n_valid;
    logic [STAT_W-1:0] r_status,   n_status;
    logic [SLOT_W-1:0] r_slot,     n_slot;
    logic              r_switched, n_switched;

    logic [TW-1:0] tgt_ext;
    logic [TW-1:0] used_ext;
    logic [IW-1:0] tgt_idx;

    function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] x,
                                                input logic [CW-1:0] used);
        logic [CW-1:0] s;
        s = CW'(x) + CW'(1);
        next_idx = (s == used) ? '0 : s[IW-1:0];
    endfunction

    assign tgt_ext  = TW'(i_target_slot);
    assign used_ext = TW'(r_used);
    assign tgt_idx  = tgt_ext[IW-1:0];

    assign o_sts.need_scan = (i_op == OP_YIELD) && r_has_run && (CW'(r_running) < r_used);
    assign o_sts.more      = (r_left != '0);
    assign o_sts.pend      = r_pend;
    assign o_sts.hit       = r_pend && (r_rd == ST_READY);

    always_comb begin
        n_used     = r_used;
        n_running  = r_running;
        n_has_run  = r_has_run;
        n_cur_run  = r_cur_run;
        n_switches = r_switches;
        n_scan_idx = r_scan_idx;
        n_left     = r_left;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_slot     = r_slot;
        n_switched = r_switched;
        mem_we     = 1'b0;
        mem_wa     = '0;
        mem_wd     = ST_UNUSED;

        if (i_cmd.exec) begin
            n_valid    = 1'b1;
            n_status   = STAT_OK;
            n_slot     = '0;
            n_switched = 1'b0;
            case (i_op)
                OP_ATTACH: begin
                    if (r_has_run) begin
                        n_status = STAT_NOTHRD;
                    end else begin
                        mem_we    = 1'b1;
                        mem_wa    = '0;
                        mem_wd    = ST_RUNNING;
                        n_used    = CW'(1);
                        n_running = '0;
                        n_has_run = 1'b1;
                        n_cur_run = 1'b1;
                    end
                end
                OP_CREATE: begin
                    if (r_used == USED_MAX) begin
                        n_status = STAT_FULL;
                    end else begin
                        mem_we = 1'b1;
                        mem_wa = r_used[IW-1:0];
                        mem_wd = ST_READY;
                        n_slot = SLOT_W'(r_used);
                        n_used = r_used + CW'(1);
                    end
                end
                OP_TERMINATE: begin
                    if (tgt_ext >= used_ext) begin
                        n_status = STAT_BADSLOT;
                    end else begin
                        mem_we = 1'b1;
                        mem_wa = tgt_idx;
                        mem_wd = ST_TERMINATED;
                        n_slot = i_target_slot;
                        if (tgt_idx == r_running) begin
                            n_cur_run = 1'b0;
                        end
                    end
                end
                OP_YIELD: begin
                    // Only reaches here when nothing is running.
                    n_status = STAT_NOTHRD;
                end
                OP_START: begin
                    if (r_used == '0) begin
                        n_status = STAT_NOTHRD;
                    end else begin
                        mem_we    = 1'b1;
                        mem_wa    = '0;
                        mem_wd    = ST_RUNNING;
                        n_running = '0;
                        n_has_run = 1'b1;
                        n_cur_run = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.scan_init) begin
            n_scan_idx = next_idx(r_running, r_used);
            n_left     = r_used - CW'(1);
            n_pend     = 1'b0;
        end

        if (i_cmd.scan_step) begin
            n_pend = (r_left != '0);
            if (r_left != '0) begin
                n_pend_idx = r_scan_idx;
                n_scan_idx = next_idx(r_scan_idx, r_used);
                n_left     = r_left - CW'(1);
            end
        end

        if (i_cmd.hit) begin
            mem_we = 1'b1;
            mem_wa = r_pend_idx;
            mem_wd = ST_RUNNING;
            n_pend = 1'b0;
        end

        if (i_cmd.miss) begin
            n_valid    = 1'b1;
            n_status   = STAT_OK;
            n_slot     = SLOT_W'(r_running);
            n_switched = 1'b0;
        end

        if (i_cmd.fix) begin
            if (r_cur_run) begin
                mem_we = 1'b1;
                mem_wa = r_running;
                mem_wd = ST_READY;
            end
            n_running  = r_pend_idx;
            n_cur_run  = 1'b1;
            n_switches = r_switches + CNT_W'(1);
            n_pend     = 1'b0;
            n_valid    = 1'b1;
            n_status   = STAT_OK;
            n_slot     = SLOT_W'(r_pend_idx);
            n_switched = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[r_scan_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_running  <= '0;
            r_has_run  <= 1'b0;
            r_cur_run  <= 1'b0;
            r_switches <= '0;
            r_pend     <= 1'b0;
            r_left     <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_used     <= n_used;
            r_running  <= n_running;
            r_has_run  <= n_has_run;
            r_cur_run  <= n_cur_run;
            r_switches <= n_switches;
            r_pend     <= n_pend;
            r_left     <= n_left;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_idx <= n_scan_idx;
        r_pend_idx <= n_pend_idx;
        r_status   <= n_status;
        r_slot     <= n_slot;
        r_switched <= n_switched;
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_slot         = r_slot;
    assign o_switched     = r_switched;
    assign o_switch_count = r_switches;

    // The current thread always lies inside the filled part of the table.
    a_running_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_has_run |-> (CW'(r_running) < r_used))
        else $error("running slot outside the filled table");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_MAX)
        else $error("fill count beyond table size");

    // The scan never looks at the current slot itself.
    a_scan_skips_current: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_pend_idx != r_running))
        else $error("scan read the current slot");

    a_count_only_on_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.fix |=> $stable(r_switches))
        else $error("switch counter moved without a switch");

    a_switch_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fix |=> (r_valid && r_switched))
        else $error("switch finished without a switched result");

endmodule

FILE: sv/round_robin_thread_scheduler.sv
// ============================================================================
// Round-robin thread scheduler
// Thread table with create, terminate, attach, start and a cyclic yield scan.
// ============================================================================
// A request (op and target_slot) is taken at a rising edge where start is
// high and busy is low. Exactly one result follows: o_valid is high for one
// cycle with o_status, o_slot, o_switched and o_switch_count, and the
// receiver must take it in that cycle because the block cannot hold it.
// Attach, create, terminate, start, unknown codes and a yield with nothing
// running need no scan: busy stays low and the result appears in the cycle
// after the request, so such requests can be issued every cycle. A yield that
// scans first sets up the scan, then reads the other used slots of the slot
// table memory once per cycle from the slot after the current one (the read
// is registered), and a found slot needs the further S_FIX state because the
// table has a single write port for the new running slot and the demoted old
// one. busy is high during the scan. The switch counter on o_switch_count
// always shows the count after the latest request and wraps at 32 bits.
// ============================================================================
module round_robin_thread_scheduler
    import rrts_pkg::*;
#(
    parameter int MAX_THREADS = MAX_THREADS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   i_op,
    input  logic [SLOT_W-1:0] i_target_slot,
    output logic              o_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [SLOT_W-1:0] o_slot,
    output logic              o_switched,
    output logic [CNT_W-1:0]  o_switch_count
);

    t_cmd cmd;
    t_sts sts;

    // The controller only sequences; all scheduler state lives in the datapath.
    rrts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    rrts_dp #(
        .MAX_THREADS (MAX_THREADS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (i_op),
        .i_target_slot  (i_target_slot),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_switched     (o_switched),
        .o_switch_count (o_switch_count)
    );

endmodule

FILE: tb/tb_round_robin_thread_scheduler.sv
// ============================================================================
// Round-robin thread scheduler testbench
// Drives attach, create, terminate, yield, start and undefined requests
// through the start/busy handshake, in bursts with random gaps. An in-bench
// thread table tracker predicts every reply, and a monitor compares each reply
// that o_valid marks against the oldest prediction.
// ============================================================================
module tb_round_robin_thread_scheduler
    import rrts_pkg::*;
();

    // Opcodes past OP_START are undefined and must answer OK with slot 0.
    localparam logic [OP_W-1:0]   OP_UNDEF_FIRST = OP_START + 1'b1;
    localparam logic [OP_W-1:0]   OP_UNDEF_LAST  = '1;
    localparam logic [SLOT_W-1:0] SLOT_LAST      = '1;

    localparam int RANDOM_REQUESTS = 1700;
    // Every this many random requests the sender holds off until all replies
    // are in, so the block is seen going fully idle mid-run.
    localparam int DRAIN_EVERY     = 400;
    localparam int MAX_SHOWN       = 10;

    // ------------------------------------------------------------------------
    // Thread table tracker: keeps its own copy of the slot table and the
    // switch counter, and queues the reply each accepted request should give.
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic              switched;
        logic [CNT_W-1:0]  count;
    } t_sched_reply;

    class thread_table_tracker;
        logic [ST_W-1:0]   slot_st [MAX_THREADS_DEF];
        int unsigned       used;
        logic [SLOT_W-1:0] cur;
        bit                live;
        logic [CNT_W-1:0]  switches;
        t_sched_reply      due_replies [$];
        int unsigned       n_requests, n_errors, n_yields, n_switches;
        int unsigned       n_full, n_nothrd, n_badslot;

        function new();
            foreach (slot_st[i]) slot_st[i] = ST_UNUSED;
            used       = 0;
            cur        = '0;
            live       = 1'b0;
            switches   = '0;
            n_requests = 0;
            n_errors   = 0;
            n_yields   = 0;
            n_switches = 0;
            n_full     = 0;
            n_nothrd   = 0;
            n_badslot  = 0;
        endfunction

        function int unsigned pending();
            return due_replies.size();
        endfunction

        // Update the table for one accepted request and queue its reply.
        function void apply_request(input logic [OP_W-1:0] op,
                                    input logic [SLOT_W-1:0] tgt);
            t_sched_reply r;
            int unsigned  idx;
            int unsigned  nxt;
            bit           hit;
            r   = '0;
            hit = 1'b0;
            nxt = 0;
            n_requests++;
            case (op)
                OP_ATTACH: begin
                    if (live) begin
                        r.status = STAT_NOTHRD;
                    end else begin
                        foreach (slot_st[i]) slot_st[i] = ST_UNUSED;
                        slot_st[0] = ST_RUNNING;
                        used       = 1;
                        cur        = '0;
                        live       = 1'b1;
                    end
                end
                OP_CREATE: begin
                    if (used >= MAX_THREADS_DEF) begin
                        r.status = STAT_FULL;
                    end else begin
                        slot_st[used] = ST_READY;
                        r.slot        = SLOT_W'(used);
                        used++;
                    end
                end
                OP_TERMINATE: begin
                    if (tgt >= used) begin
                        r.status = STAT_BADSLOT;
                    end else begin
                        slot_st[tgt] = ST_TERMINATED;
                        r.slot       = tgt;
                    end
                end
                OP_YIELD: begin
                    n_yields++;
                    if (!live || used == 0 || cur >= used) begin
                        r.status = STAT_NOTHRD;
                    end else begin
                        // Cyclic search starting just after the current slot.
                        for (int k = 1; k < used; k++) begin
                            idx = (cur + k) % used;
                            if (!hit && slot_st[idx] == ST_READY) begin
                                hit = 1'b1;
                                nxt = idx;
                            end
                        end
                        if (hit) begin
                            // A terminated current thread is not brought back.
                            if (slot_st[cur] == ST_RUNNING) slot_st[cur] = ST_READY;
                            cur          = SLOT_W'(nxt);
                            slot_st[nxt] = ST_RUNNING;
                            switches++;
                            r.switched   = 1'b1;
                            n_switches++;
                        end
                        r.slot = cur;
                    end
                end
                OP_START: begin
                    if (used == 0) begin
                        r.status = STAT_NOTHRD;
                    end else begin
                        // The old current slot keeps whatever state it had.
                        cur        = '0;
                        slot_st[0] = ST_RUNNING;
                        live       = 1'b1;
                    end
                end
                default: ;
            endcase
            r.count = switches;
            due_replies.push_back(r);
        endfunction

        // Compare one reply from the block with the oldest prediction.
        function void check_reply(input logic [STAT_W-1:0] status,
                                  input logic [SLOT_W-1:0] slot,
                                  input logic              switched,
                                  input logic [CNT_W-1:0]  count);
            t_sched_reply want;
            bit           bad;
            if (due_replies.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_SHOWN)
                    $display("%0t: reply with none pending: status %0d slot %0d sw %0d cnt %0d",
                             $time, status, slot, switched, count);
                return;
            end
            want = due_replies.pop_front();
            case (want.status)
                STAT_FULL:    n_full++;
                STAT_NOTHRD:  n_nothrd++;
                STAT_BADSLOT: n_badslot++;
                default: ;
            endcase
            bad = 1'b0;
            if (status   !== want.status)   bad = 1'b1;
            if (slot     !== want.slot)     bad = 1'b1;
            if (switched !== want.switched) bad = 1'b1;
            if (count    !== want.count)    bad = 1'b1;
            if (bad) begin
                n_errors++;
                if (n_errors <= MAX_SHOWN)
                    $display("%0t: exp/act status %0d/%0d slot %0d/%0d sw %0d/%0d cnt %0d/%0d",
                             $time, want.status, status, want.slot, slot,
                             want.switched, switched, want.count, count);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   i_op;
    logic [SLOT_W-1:0] i_target_slot;
    logic              o_valid;
    logic [STAT_W-1:0] o_status;
    logic [SLOT_W-1:0] o_slot;
    logic              o_switched;
    logic [CNT_W-1:0]  o_switch_count;

    thread_table_tracker tracker;

    round_robin_thread_scheduler dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_target_slot  (i_target_slot),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_switched     (o_switched),
        .o_switch_count (o_switch_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Safety net: a correct run needs well under a tenth of this time, even
    // with every yield scanning the full table and every gap at its longest.
    initial begin
        #5_000_000;
        $display("round_robin_thread_scheduler: mismatch");
        $finish;
    end

    // The block cannot hold a reply back, so every o_valid cycle is a reply
    // taken at the edge that closes it. Values seen here are the ones from
    // before the edge, since the block and the drivers both update with
    // nonblocking assignments.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            tracker.check_reply(o_status, o_slot, o_switched, o_switch_count);
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // Present one request and wait for the edge that takes it (start high,
    // busy low). start is left high, so a caller that sends again at once keeps
    // it high without a glitch; a caller that pauses lowers it first.
    task automatic send(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] tgt);
        start         <= 1'b1;
        i_op          <= op;
        i_target_slot <= tgt;
        do @(posedge i_clk); while (busy);
        tracker.apply_request(op, tgt);
    endtask

    // Stop sending and wait until every predicted reply has been seen. At
    // least one edge passes, so start is never lowered and raised in one step.
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned       n;
        int unsigned       burst;
        int unsigned       gap;
        int unsigned       roll;
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] tgt;

        tracker = new();

        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_op          <= OP_ATTACH;
        i_target_slot <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening. Nothing is running yet, so the error answers for
        // an empty table come first, then a create ahead of any attach, the
        // undefined opcodes, and the single successful attach of the run.
        send(OP_YIELD, '0);                 // yield with nothing current
        send(OP_START, '0);                 // start with an empty table
        send(OP_TERMINATE, '0);             // terminate in an empty table
        send(OP_CREATE, SLOT_LAST);         // create before any attach
        send(OP_TERMINATE, SLOT_LAST);      // highest slot, not in use
        send(OP_UNDEF_FIRST, 4'd5);
        send(OP_UNDEF_FIRST + 1'b1, 4'd10);
        send(OP_UNDEF_LAST, SLOT_LAST);
        send(OP_ATTACH, '0);                // wipes the table, slot 0 runs
        send(OP_ATTACH, '0);                // already attached
        send(OP_YIELD, '0);                 // no other ready slot
        send(OP_CREATE, '0);
        send(OP_CREATE, '0);
        send(OP_YIELD, '0);                 // 0 -> 1
        send(OP_TERMINATE, 4'd1);           // terminate the running thread
        send(OP_YIELD, '0);                 // 1 -> 2, slot 1 stays terminated
        send(OP_YIELD, '0);                 // wraps 2 -> 0
        send(OP_TERMINATE, 4'd3);           // just past the used slots
        send(OP_YIELD, '0);                 // 0 -> 2, skipping slot 1
        send(OP_START, '0);                 // start while slot 2 is running
        send(OP_YIELD, '0);                 // slot 2 is stuck running: no switch
        drain();

        // Random part. Yields dominate; creates fill the table early and then
        // exercise the full answer. Terminates and starts are kept rare: both
        // take slots out of the ready pool for good, and a start away from
        // slot 0 leaves the old slot marked running forever, so most of those
        // are turned into yields. Undefined opcodes and attaches are noise.
        n = 0;
        while (n < RANDOM_REQUESTS) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 10);
            for (int b = 0; b < burst && n < RANDOM_REQUESTS; b++) begin
                roll = $urandom_range(0, 99);
                tgt  = SLOT_W'($urandom_range(0, SLOT_LAST));
                if (roll < 2) begin
                    op = OP_ATTACH;
                end else if (roll < 24) begin
                    op = OP_CREATE;
                end else if (roll < 26) begin
                    op = OP_TERMINATE;
                    if (tracker.live && $urandom_range(0, 1) == 1) tgt = tracker.cur;
                end else if (roll < 91) begin
                    op = OP_YIELD;
                end else if (roll < 94) begin
                    op = (tracker.cur != '0 && $urandom_range(0, 3) != 0) ? OP_YIELD
                                                                          : OP_START;
                end else begin
                    op = OP_W'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
                end
                send(op, tgt);
                n++;
                if (n % DRAIN_EVERY == 0) drain();
            end
            // Gaps of zero keep some bursts back to back.
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end

        // Wait out every reply, then a full scan's worth of cycles more so
        // that a stray late reply would still be caught.
        drain();
        repeat (MAX_THREADS_DEF + 4) @(posedge i_clk);

        if (tracker.pending() != 0) begin
            $display("%0d predicted replies never arrived", tracker.pending());
            tracker.n_errors++;
        end

        $display("Covered %0d requests, %0d of them yields, making %0d thread switches.",
                 tracker.n_requests, tracker.n_yields, tracker.n_switches);
        $display("Error answers: %0d table full, %0d no thread or attached, %0d bad slot.",
                 tracker.n_full, tracker.n_nothrd, tracker.n_badslot);

        if (tracker.n_errors == 0) begin
            $display("round_robin_thread_scheduler: match");
        end else begin
            $display("%0d failing replies in total", tracker.n_errors);
            $display("round_robin_thread_scheduler: mismatch");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/rrts_pkg.sv
sv/rrts_ctrl.sv
sv/rrts_dp.sv
sv/round_robin_thread_scheduler.sv
tb/tb_round_robin_thread_scheduler.sv
